### sv/swt_pkg.sv
package swt_pkg;

    localparam int unsigned MAP_BITS       = 64;
    localparam int unsigned LEN_BITS       = 8;
    localparam int unsigned TOK_OFF_BITS   = 32;
    localparam int unsigned CFG_INDEX_BITS = 3;

    localparam logic [7:0] BLANK_BYTE = 8'h20;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_LOW   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_MID   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_UPPER = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_TOP   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_WORD  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_GAP   = 3'd5;

    // reset values: digits, ASCII letters, nothing above 127
    localparam logic [MAP_BITS-1:0] MAP_LOW_RST   = 64'h03FF_0000_0000_0000;
    localparam logic [MAP_BITS-1:0] MAP_MID_RST   = 64'h07FF_FFFE_07FF_FFFE;
    localparam logic [MAP_BITS-1:0] MAP_UPPER_RST = 64'h0;
    localparam logic [MAP_BITS-1:0] MAP_TOP_RST   = 64'h0;
    localparam logic [LEN_BITS-1:0] MAX_LEN_RST   = 8'd255;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_GAP   = 2'd2,
        MODE_BLANK = 2'd3
    } t_mode;

    typedef struct packed {
        logic [TOK_OFF_BITS-1:0] token_offset;
        logic [LEN_BITS-1:0]     token_length;
        logic                    is_word;
        logic                    closes_doc;
        logic                    last_of_run;
    } t_token;

endpackage

### sv/swt_in_if.sv
interface swt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       doc_end;

    modport source (output valid, output text_byte, output doc_end, input ready);
    modport sink   (input valid, input text_byte, input doc_end, output ready);
endinterface

### sv/swt_out_if.sv
interface swt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] token_offset;
    logic [7:0]  token_length;
    logic        is_word;
    logic        closes_doc;
    logic        last_of_run;

    modport source (output valid, output token_offset, output token_length,
                    output is_word, output closes_doc, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_offset, input token_length,
                    input is_word, input closes_doc, input last_of_run,
                    output ready);
endinterface

### sv/spaceless_word_tokenizer.sv
// Channel | Dir | Beat contents                                         | Handshake
// i_in    | in  | text_byte, doc_end                                    | valid/ready
// o_out   | out | token_offset, token_length, is_word, closes_doc,      | valid/ready
//         |     | last_of_run                                           |
// i_cfg_* | in  | register index, 64-bit write data                     | write enable only
//
// Each byte is classified and the scan state updated in the cycle it is taken; its
// tokens (zero, one or two) land in a two-slot result register the next cycle.
// A byte giving at most one token keeps one byte per cycle while output is ready;
// a byte giving two tokens holds the input until the first of them is taken.
// Reset (synchronous, active low) restores the class map and limits, empties the
// result slots and returns the scanner to idle at offset zero.
// A token left waiting on a stalled output blocks new bytes until it is taken.
module spaceless_word_tokenizer #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    swt_in_if.sink                            i_in,
    swt_out_if.source                         o_out,
    input  logic                              i_cfg_wr_en,
    input  logic [swt_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [swt_pkg::MAP_BITS-1:0]       i_cfg_wdata
);
    import swt_pkg::*;

    // configuration
    logic [MAP_BITS-1:0] r_map_low, r_map_mid, r_map_upper, r_map_top;
    logic [LEN_BITS-1:0] r_max_word, r_max_gap;

    // scan state
    t_mode                  r_mode, n_mode;
    logic [LEN_BITS-1:0]    r_len, n_len;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;

    // result slots
    logic [1:0] r_cnt, n_cnt;
    t_token     r_slot0, r_slot1, n_slot0, n_slot1;

    logic                in_fire, out_fire;
    logic [255:0]        class_map;
    logic                cls, not_blank;
    logic [LEN_BITS-1:0] lim_word, lim_gap, len_inc;
    logic                ot_emit;
    t_mode               ot_mode;
    t_mode               m_mode;
    logic [LEN_BITS-1:0] m_len;
    logic [OFFSET_BITS-1:0] m_off;
    logic                a_v, b_v, c_v;
    t_token              tok_a, tok_b, tok_c;
    logic [1:0]          new_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_low   <= MAP_LOW_RST;
            r_map_mid   <= MAP_MID_RST;
            r_map_upper <= MAP_UPPER_RST;
            r_map_top   <= MAP_TOP_RST;
            r_max_word  <= MAX_LEN_RST;
            r_max_gap   <= MAX_LEN_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAP_LOW:   r_map_low   <= i_cfg_wdata;
                CFG_MAP_MID:   r_map_mid   <= i_cfg_wdata;
                CFG_MAP_UPPER: r_map_upper <= i_cfg_wdata;
                CFG_MAP_TOP:   r_map_top   <= i_cfg_wdata;
                CFG_MAX_WORD:  r_max_word  <= i_cfg_wdata[LEN_BITS-1:0];
                CFG_MAX_GAP:   r_max_gap   <= i_cfg_wdata[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign class_map = {r_map_top, r_map_upper, r_map_mid, r_map_low};
    assign cls       = class_map[i_in.text_byte];
    assign not_blank = (i_in.text_byte != BLANK_BYTE);
    // a zero limit behaves as one
    assign lim_word  = (r_max_word == '0) ? LEN_BITS'(1) : r_max_word;
    assign lim_gap   = (r_max_gap == '0) ? LEN_BITS'(1) : r_max_gap;
    assign len_inc   = r_len + LEN_BITS'(1);

    // a token opened by this byte from idle
    always_comb begin
        if (cls) begin
            ot_emit = (lim_word == LEN_BITS'(1));
            ot_mode = ot_emit ? MODE_IDLE : MODE_WORD;
        end else if (not_blank) begin
            ot_emit = (lim_gap == LEN_BITS'(1));
            ot_mode = ot_emit ? MODE_IDLE : MODE_GAP;
        end else begin
            ot_emit = 1'b0;
            ot_mode = MODE_BLANK;
        end
    end

    // next scan state, before the document-end override
    always_comb begin
        m_mode = ot_mode;
        m_len  = (ot_mode == MODE_IDLE) ? '0 : LEN_BITS'(1);
        m_off  = (ot_mode == MODE_IDLE) ? '0 : r_pos;
        case (r_mode)
            MODE_WORD: begin
                if (cls) begin
                    if (len_inc >= lim_word) begin
                        m_mode = MODE_IDLE;
                        m_len  = '0;
                        m_off  = '0;
                    end else begin
                        m_mode = MODE_WORD;
                        m_len  = len_inc;
                        m_off  = r_off;
                    end
                end
            end
            MODE_GAP: begin
                if (!cls) begin
                    if (len_inc >= lim_gap) begin
                        m_mode = MODE_IDLE;
                        m_len  = '0;
                        m_off  = '0;
                    end else begin
                        m_mode = MODE_GAP;
                        m_len  = len_inc;
                        m_off  = r_off;
                    end
                end
            end
            MODE_BLANK: begin
                // blank then separator byte: blank joins the separator
                if (!cls && lim_gap > LEN_BITS'(1)) begin
                    if (lim_gap <= LEN_BITS'(2)) begin
                        m_mode = MODE_IDLE;
                        m_len  = '0;
                        m_off  = '0;
                    end else begin
                        m_mode = MODE_GAP;
                        m_len  = LEN_BITS'(2);
                        m_off  = r_off;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (i_in.doc_end) begin
            n_mode = MODE_IDLE;
            n_len  = '0;
            n_off  = '0;
            n_pos  = '0;
        end else begin
            n_mode = m_mode;
            n_len  = m_len;
            n_off  = m_off;
            n_pos  = (r_pos != '1) ? r_pos + OFFSET_BITS'(1) : r_pos;
        end
    end

    // tokens: a closes the open run, b is a token opened and cut at once,
    // c flushes whatever is open at document end
    always_comb begin
        a_v   = 1'b0;
        b_v   = 1'b0;
        tok_a = '{token_offset: TOK_OFF_BITS'(r_off), token_length: r_len,
                  is_word: 1'b0, closes_doc: 1'b0, last_of_run: 1'b0};
        tok_b = '{token_offset: TOK_OFF_BITS'(r_pos), token_length: LEN_BITS'(1),
                  is_word: cls, closes_doc: 1'b0, last_of_run: 1'b0};
        case (r_mode)
            MODE_WORD: begin
                tok_a.is_word = 1'b1;
                if (cls) begin
                    a_v                = (len_inc >= lim_word);
                    tok_a.token_length = len_inc;
                end else begin
                    a_v = 1'b1;
                    b_v = ot_emit;
                end
            end
            MODE_GAP: begin
                if (!cls) begin
                    a_v                = (len_inc >= lim_gap);
                    tok_a.token_length = len_inc;
                end else begin
                    a_v = 1'b1;
                    b_v = ot_emit;
                end
            end
            MODE_BLANK: begin
                if (cls) begin
                    b_v = ot_emit;
                end else if (lim_gap == LEN_BITS'(1)) begin
                    a_v                = 1'b1;
                    tok_a.token_length = LEN_BITS'(1);
                    b_v                = ot_emit;
                end else begin
                    a_v                = (lim_gap <= LEN_BITS'(2));
                    tok_a.token_length = LEN_BITS'(2);
                end
            end
            default: b_v = ot_emit;
        endcase

        c_v   = i_in.doc_end && (m_mode != MODE_IDLE);
        tok_c = '{token_offset: TOK_OFF_BITS'(m_off),
                  token_length: (m_mode == MODE_BLANK) ? LEN_BITS'(1) : m_len,
                  is_word: (m_mode == MODE_WORD), closes_doc: 1'b0, last_of_run: 1'b0};
    end

    assign new_cnt = 2'(a_v) + 2'(b_v) + 2'(c_v);

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (in_fire) begin
            n_cnt   = new_cnt;
            n_slot0 = a_v ? tok_a : (b_v ? tok_b : tok_c);
            n_slot1 = a_v ? (b_v ? tok_b : tok_c) : tok_c;
            if (new_cnt == 2'd1) begin
                n_slot0.last_of_run = 1'b1;
                n_slot0.closes_doc  = i_in.doc_end;
            end
            n_slot1.last_of_run = 1'b1;
            n_slot1.closes_doc  = i_in.doc_end;
        end else if (out_fire) begin
            n_cnt   = r_cnt - 2'd1;
            n_slot0 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_len  <= '0;
            r_off  <= '0;
            r_pos  <= '0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (in_fire) begin
                r_mode <= n_mode;
                r_len  <= n_len;
                r_off  <= n_off;
                r_pos  <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.token_offset = r_slot0.token_offset;
    assign o_out.token_length = r_slot0.token_length;
    assign o_out.is_word      = r_slot0.is_word;
    assign o_out.closes_doc   = r_slot0.closes_doc;
    assign o_out.last_of_run  = r_slot0.last_of_run;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import swt_pkg::*;

    localparam int unsigned OFFSET_BITS   = 32;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_BYTES  = 80;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [MAP_BITS-1:0]       cfg_wdata;

    swt_in_if  in_if();
    swt_out_if out_if();

    spaceless_word_tokenizer #(
        .OFFSET_BITS(OFFSET_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata)
    );

    // shadow copy of the register file and the scanner
    logic [MAP_BITS-1:0]    class_map [4];
    logic [LEN_BITS-1:0]    word_cap_reg;
    logic [LEN_BITS-1:0]    gap_cap_reg;
    t_mode                  scan_mode_q;
    int unsigned            run_len_q;
    logic [OFFSET_BITS-1:0] run_off_q;
    logic [OFFSET_BITS-1:0] byte_pos_q;

    t_token     step_tokens[$];
    t_token     expected_tokens[$];
    logic [7:0] doc_bytes[$];

    int unsigned mismatches;
    int unsigned tokens_checked;
    int unsigned bytes_sent;
    int unsigned docs_sent;
    int unsigned cfg_writes;
    bit          sender_gaps_on;
    bit          rx_stalls_on;
    int unsigned hold_req;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------- token predictor ----------------

    function automatic bit is_word_char(logic [7:0] b);
        return class_map[b[7:6]][b[5:0]];
    endfunction

    // a zero limit behaves as one
    function automatic int unsigned cap_of(logic [LEN_BITS-1:0] r);
        return (r == 0) ? 1 : int'(r);
    endfunction

    function automatic void emit_token(logic [OFFSET_BITS-1:0] off, int unsigned len, bit word);
        t_token t;
        t = '0;
        t.token_offset = off[TOK_OFF_BITS-1:0];
        t.token_length = len[LEN_BITS-1:0];
        t.is_word      = word;
        step_tokens.push_back(t);
    endfunction

    function automatic void scan_to_idle();
        scan_mode_q = MODE_IDLE;
        run_len_q   = 0;
        run_off_q   = '0;
    endfunction

    function automatic void reset_shadow();
        class_map[0] = MAP_LOW_RST;
        class_map[1] = MAP_MID_RST;
        class_map[2] = MAP_UPPER_RST;
        class_map[3] = MAP_TOP_RST;
        word_cap_reg = MAX_LEN_RST;
        gap_cap_reg  = MAX_LEN_RST;
        scan_to_idle();
        byte_pos_q = '0;
    endfunction

    function automatic void start_token(logic [7:0] b, logic [OFFSET_BITS-1:0] pos);
        run_off_q = pos;
        run_len_q = 1;
        if (is_word_char(b)) begin
            scan_mode_q = MODE_WORD;
            if (run_len_q >= cap_of(word_cap_reg)) begin
                emit_token(run_off_q, run_len_q, 1'b1);
                scan_to_idle();
            end
        end else if (b != BLANK_BYTE) begin
            scan_mode_q = MODE_GAP;
            if (run_len_q >= cap_of(gap_cap_reg)) begin
                emit_token(run_off_q, run_len_q, 1'b0);
                scan_to_idle();
            end
        end else begin
            scan_mode_q = MODE_BLANK;
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] b, bit closing);
        logic [OFFSET_BITS-1:0] pos;
        bit                     cls;
        int                     n;
        pos = byte_pos_q;
        cls = is_word_char(b);
        step_tokens.delete();
        case (scan_mode_q)
            MODE_WORD: begin
                if (cls) begin
                    run_len_q++;
                    if (run_len_q >= cap_of(word_cap_reg)) begin
                        emit_token(run_off_q, run_len_q, 1'b1);
                        scan_to_idle();
                    end
                end else begin
                    emit_token(run_off_q, run_len_q, 1'b1);
                    scan_to_idle();
                    start_token(b, pos);
                end
            end
            MODE_GAP: begin
                if (!cls) begin
                    run_len_q++;
                    if (run_len_q >= cap_of(gap_cap_reg)) begin
                        emit_token(run_off_q, run_len_q, 1'b0);
                        scan_to_idle();
                    end
                end else begin
                    emit_token(run_off_q, run_len_q, 1'b0);
                    scan_to_idle();
                    start_token(b, pos);
                end
            end
            MODE_BLANK: begin
                if (cls) begin
                    // lone blank before a word is dropped
                    scan_to_idle();
                    start_token(b, pos);
                end else if (cap_of(gap_cap_reg) <= 1) begin
                    emit_token(run_off_q, 1, 1'b0);
                    scan_to_idle();
                    start_token(b, pos);
                end else begin
                    scan_mode_q = MODE_GAP;
                    run_len_q   = 2;
                    if (run_len_q >= cap_of(gap_cap_reg)) begin
                        emit_token(run_off_q, run_len_q, 1'b0);
                        scan_to_idle();
                    end
                end
            end
            default: start_token(b, pos);
        endcase

        if (closing) begin
            case (scan_mode_q)
                MODE_WORD:  emit_token(run_off_q, run_len_q, 1'b1);
                MODE_GAP:   emit_token(run_off_q, run_len_q, 1'b0);
                MODE_BLANK: emit_token(run_off_q, 1, 1'b0);
                default: ;
            endcase
            n = step_tokens.size();
            if (n > 0)
                step_tokens[n-1].closes_doc = 1'b1;
            scan_to_idle();
            byte_pos_q = '0;
        end else if (pos < OFFSET_MAX) begin
            byte_pos_q = pos + 1'b1;
        end

        n = step_tokens.size();
        if (n > 0)
            step_tokens[n-1].last_of_run = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endfunction

    // ---------------- stimulus helpers ----------------

    // mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_word_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        for (int i = 0; i < 32; i++) begin
            if (is_word_char(b))
                return b;
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_sep_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        for (int i = 0; i < 32; i++) begin
            if (!is_word_char(b) && b != BLANK_BYTE)
                return b;
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // run lengths that straddle small caps but stay short
    function automatic int unsigned run_span(logic [LEN_BITS-1:0] r);
        int unsigned lim;
        lim = cap_of(r);
        return (lim < 10) ? lim + 1 : 10;
    endfunction

    function automatic void compose_document(int unsigned target);
        int unsigned n;
        int unsigned kind;
        doc_bytes.delete();
        while (doc_bytes.size() < target) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    n = $urandom_range(1, run_span(word_cap_reg));
                    repeat (n) doc_bytes.push_back(pick_word_byte());
                end
                4, 5: doc_bytes.push_back(BLANK_BYTE);
                6, 7: begin
                    n = $urandom_range(1, run_span(gap_cap_reg));
                    repeat (n)
                        doc_bytes.push_back(($urandom_range(0, 3) == 0) ? BLANK_BYTE
                                                                       : pick_sep_byte());
                end
                8: begin
                    doc_bytes.push_back(BLANK_BYTE);
                    doc_bytes.push_back(pick_sep_byte());
                end
                default: doc_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            doc_bytes.push_back(BLANK_BYTE);
    endfunction

    task automatic send_byte(logic [7:0] b, bit closing);
        int unsigned gap;
        gap = sender_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.text_byte <= b;
        in_if.doc_end   <= closing;
        do @(posedge i_clk); while (!in_if.ready);
        tokenize_byte(b, closing);
        bytes_sent++;
        if (closing)
            docs_sent++;
    endtask

    task automatic send_text(string s, bit closing);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], closing && (i == s.len() - 1));
    endtask

    task automatic send_document();
        foreach (doc_bytes[i])
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    endtask

    // drop valid, let every token drain, then allow the scanner to settle
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [MAP_BITS-1:0] data);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_MAP_LOW:   class_map[0] = data;
            CFG_MAP_MID:   class_map[1] = data;
            CFG_MAP_UPPER: class_map[2] = data;
            CFG_MAP_TOP:   class_map[3] = data;
            CFG_MAX_WORD:  word_cap_reg = data[LEN_BITS-1:0];
            CFG_MAX_GAP:   gap_cap_reg  = data[LEN_BITS-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_INDEX_BITS-1:0] map_reg(int i);
        case (i)
            0:       return CFG_MAP_LOW;
            1:       return CFG_MAP_MID;
            2:       return CFG_MAP_UPPER;
            default: return CFG_MAP_TOP;
        endcase
    endfunction

    function automatic logic [MAP_BITS-1:0] map_reset(int i);
        case (i)
            0:       return MAP_LOW_RST;
            1:       return MAP_MID_RST;
            2:       return MAP_UPPER_RST;
            default: return MAP_TOP_RST;
        endcase
    endfunction

    function automatic logic [LEN_BITS-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            3:       return 8'd2;
            default: return 8'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic restore_defaults();
        for (int i = 0; i < 4; i++)
            write_reg(map_reg(i), map_reset(i));
        write_reg(CFG_MAX_WORD, {56'd0, MAX_LEN_RST});
        write_reg(CFG_MAX_GAP,  {56'd0, MAX_LEN_RST});
    endtask

    task automatic random_settings();
        logic [MAP_BITS-1:0] m;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 7))
                0, 1: m = map_reset(i);
                2:    m = '1;
                3:    m = '0;
                default: begin
                    m = {$urandom, $urandom};
                    // keep the blank a separator most of the time
                    if (i == 0 && $urandom_range(0, 3) != 0)
                        m[BLANK_BYTE[5:0]] = 1'b0;
                end
            endcase
            write_reg(map_reg(i), m);
        end
        // upper data bits are don't-care for the 8-bit limits
        write_reg(CFG_MAX_WORD, {$urandom, 24'($urandom_range(0, 16777215)), pick_limit()});
        write_reg(CFG_MAX_GAP,  {$urandom, 24'($urandom_range(0, 16777215)), pick_limit()});
    endtask

    // ---------------- result checker ----------------

    function automatic void report_token(string what, t_token want, t_token got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%s: expected off=%0d len=%0d word=%0b close=%0b last=%0b, ",
                   what, want.token_offset, want.token_length, want.is_word,
                   want.closes_doc, want.last_of_run);
            $display("got off=%0d len=%0d word=%0b close=%0b last=%0b",
                     got.token_offset, got.token_length, got.is_word,
                     got.closes_doc, got.last_of_run);
        end
    endfunction

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.token_offset = out_if.token_offset;
            got.token_length = out_if.token_length;
            got.is_word      = out_if.is_word;
            got.closes_doc   = out_if.closes_doc;
            got.last_of_run  = out_if.last_of_run;
            if (expected_tokens.size() == 0) begin
                report_token("unexpected token", '0, got);
            end else begin
                want = expected_tokens.pop_front();
                tokens_checked++;
                if (got.token_offset !== want.token_offset ||
                    got.token_length !== want.token_length ||
                    got.is_word      !== want.is_word ||
                    got.closes_doc   !== want.closes_doc ||
                    got.last_of_run  !== want.last_of_run)
                    report_token("token mismatch", want, got);
            end
        end
    end

    // token sink: random stalls plus an optional long hold-off
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_default_tokens();
        // word, dropped blank, blank into separator, 0xFF closing a separator
        send_text("ab c, ", 1'b0);
        send_byte(8'hFF, 1'b1);
        // blank alone at document end
        send_byte(BLANK_BYTE, 1'b1);
        // word and trailing blank closed by the same beat
        send_text("x ", 1'b1);
        send_byte(8'h00, 1'b0);
        send_text("9", 1'b1);
        wait_idle();
    endtask

    task automatic test_length_caps();
        write_reg(CFG_MAX_WORD, 64'd2);
        write_reg(CFG_MAX_GAP,  64'd1);
        // cut word; blank before non-word with a gap limit of one
        send_text("abc ,", 1'b1);
        // document ends on the byte that hits the cap
        send_text("ab", 1'b1);
        wait_idle();
        write_reg(CFG_MAX_WORD, 64'd0);
        write_reg(CFG_MAX_GAP,  64'd0);
        send_text("a ;", 1'b1);
        wait_idle();
        write_reg(CFG_MAX_WORD, 64'hFFFF_FFFF_FFFF_FF03);
        write_reg(CFG_MAX_GAP,  64'h8000_0000_0000_0003);
        send_text(" ,;x", 1'b1);
        wait_idle();
    endtask

    task automatic test_long_runs();
        restore_defaults();
        doc_bytes.delete();
        repeat (256) doc_bytes.push_back(pick_word_byte());
        repeat (4) doc_bytes.push_back(pick_sep_byte());
        send_document();
        wait_idle();
    endtask

    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        hold_req = 300;
        // every closing blank yields two tokens from one beat
        repeat (10) send_text("x ", 1'b1);
        wait_idle();
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_random_documents();
        int unsigned start_bytes;
        int unsigned docs;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            random_settings();
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stalls_on   = ($urandom_range(0, 3) != 0);
            docs = $urandom_range(3, 6);
            repeat (docs) begin
                compose_document($urandom_range(1, 24));
                send_document();
            end
            wait_idle();
        end
        sender_gaps_on = 1'b1;
        rx_stalls_on   = 1'b1;
    endtask

    initial begin
        in_if.valid     = 1'b0;
        in_if.text_byte = 8'h00;
        in_if.doc_end   = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_MAP_LOW;
        cfg_wdata       = '0;
        i_rst_n         = 1'b0;
        mismatches      = 0;
        tokens_checked  = 0;
        bytes_sent      = 0;
        docs_sent       = 0;
        cfg_writes      = 0;
        sender_gaps_on  = 1'b1;
        rx_stalls_on    = 1'b1;
        hold_req        = 0;
        reset_shadow();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_tokens();
        test_length_caps();
        test_long_runs();
        test_backpressure();
        test_random_documents();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (expected_tokens.size() != 0)
            mismatches += expected_tokens.size();

        $display("Sent %0d bytes in %0d documents across %0d register writes.",
                 bytes_sent, docs_sent, cfg_writes);
        $display("Checked %0d tokens, %0d mismatches.", tokens_checked, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d tokens outstanding.", expected_tokens.size());
        $display("FAILURE");
        $finish;
    end

endmodule
